@@ rtl/core/srna_pkg.sv @@
package srna_pkg;

  localparam int NUM_W    = 7;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int LETTER_W = 5;

  localparam logic [OP_W-1:0] OP_ASSIGN      = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOCATE    = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE     = 3'd2;
  localparam logic [OP_W-1:0] OP_HIGHEST     = 3'd3;
  localparam logic [OP_W-1:0] OP_DESCRIBE    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR_NAMED = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

  // letter codes are base 26; x / 26 == (x * 79) >> 11 for x below 256
  localparam int LETTER_BASE  = 26;
  localparam int RECIP_MUL    = 79;
  localparam int RECIP_SHIFT  = 11;
  localparam int RECIP_MUL_W  = 7;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [NUM_W-1:0] number;
  } req_t;

  typedef struct packed {
    logic [NUM_W-1:0]    result_number;
    logic [STATUS_W-1:0] status;
    logic                is_temporary;
    logic [LETTER_W-1:0] letter_high;
    logic [LETTER_W-1:0] letter_low;
  } rsp_t;

endpackage

@@ rtl/core/srna_input_stage.sv @@
module srna_input_stage
  import srna_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  input  logic advance_i,
  output logic req_valid_o,
  output req_t req_o
);

  logic valid_q, valid_d;
  req_t req_q;
  logic take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= in_data_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

@@ rtl/core/srna_map_core.sv @@
module srna_map_core
  import srna_pkg::*;
#(
  parameter int NAMED_SLOTS = 16,
  parameter int TOTAL_SLOTS = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic commit_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  localparam int NamedEff = (NAMED_SLOTS < TOTAL_SLOTS) ? NAMED_SLOTS : TOTAL_SLOTS;
  localparam int IdxW     = $clog2(TOTAL_SLOTS);
  localparam int SlotW    = (IdxW > NUM_W) ? IdxW : NUM_W;
  localparam int NumSpan  = 1 << NUM_W;
  localparam int ProdW    = SlotW + RECIP_MUL_W;

  logic [TOTAL_SLOTS-1:0] used_q, used_d;
  logic [TOTAL_SLOTS-1:0] set_mask, clr_mask;
  logic [NumSpan-1:0]     view;

  logic             named_free, temp_free;
  logic [SlotW-1:0] named_idx, temp_idx, high_idx;
  logic [SlotW-1:0] grant_idx, letter_src, offset;
  logic             grant_en, release_en, clear_en;
  logic             hit;
  logic [ProdW-1:0] prod;
  logic [LETTER_W-1:0] quo, rem;
  rsp_t             rsp;

  // flat priority encoders over the map
  always_comb begin
    named_free = 1'b0;
    named_idx  = '0;
    temp_free  = 1'b0;
    temp_idx   = '0;
    high_idx   = '0;
    for (int k = NamedEff - 1; k >= 0; k--) begin
      if (!used_q[k]) begin
        named_free = 1'b1;
        named_idx  = SlotW'(k);
      end
    end
    for (int k = TOTAL_SLOTS - 1; k >= NamedEff; k--) begin
      if (!used_q[k]) begin
        temp_free = 1'b1;
        temp_idx  = SlotW'(k);
      end
    end
    for (int k = NamedEff; k < TOTAL_SLOTS; k++) begin
      if (used_q[k]) begin
        high_idx = SlotW'(k);
      end
    end
  end

  // map as seen through the 7-bit number field; out of range reads as free
  always_comb begin
    for (int k = 0; k < NumSpan; k++) begin
      view[k] = 1'b0;
      if (k < TOTAL_SLOTS) begin
        view[k] = used_q[k];
      end
    end
  end

  assign hit = view[req_i.number];

  // base-26 split of the temporary offset
  assign letter_src = (req_i.operation == OP_ALLOCATE) ? temp_idx
                                                       : SlotW'(req_i.number);
  assign offset = letter_src - SlotW'(NamedEff);
  assign prod   = ProdW'(offset) * ProdW'(RECIP_MUL);
  assign quo    = LETTER_W'(prod >> RECIP_SHIFT);
  assign rem    = LETTER_W'(offset - SlotW'(quo) * SlotW'(LETTER_BASE));

  always_comb begin
    rsp        = '0;
    grant_en   = 1'b0;
    grant_idx  = '0;
    release_en = 1'b0;
    clear_en   = 1'b0;
    case (req_i.operation)
      OP_ASSIGN: begin
        if (named_free) begin
          grant_en           = 1'b1;
          grant_idx          = named_idx;
          rsp.result_number  = named_idx[NUM_W-1:0];
        end else begin
          rsp.status = ST_NO_FREE;
        end
      end
      OP_ALLOCATE: begin
        if (temp_free) begin
          grant_en          = 1'b1;
          grant_idx         = temp_idx;
          rsp.result_number = temp_idx[NUM_W-1:0];
          rsp.is_temporary  = 1'b1;
          rsp.letter_high   = quo;
          rsp.letter_low    = rem;
        end else begin
          rsp.status = ST_NO_FREE;
        end
      end
      OP_RELEASE: begin
        if (hit) begin
          release_en = 1'b1;
        end else begin
          rsp.status = ST_NOT_USED;
        end
      end
      OP_HIGHEST: begin
        rsp.result_number = high_idx[NUM_W-1:0];
      end
      OP_DESCRIBE: begin
        if (hit) begin
          rsp.result_number = req_i.number;
          if (SlotW'(req_i.number) >= SlotW'(NamedEff)) begin
            rsp.is_temporary = 1'b1;
            rsp.letter_high  = quo;
            rsp.letter_low   = rem;
          end
        end else begin
          rsp.status = ST_NOT_USED;
        end
      end
      OP_CLEAR_NAMED: begin
        clear_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < TOTAL_SLOTS; k++) begin
      set_mask[k] = grant_en && (grant_idx == SlotW'(k));
      clr_mask[k] = (release_en && (SlotW'(req_i.number) == SlotW'(k)))
                 || (clear_en && (k < NamedEff));
    end
    used_d = commit_i ? ((used_q & ~clr_mask) | set_mask) : used_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign rsp_o = rsp;

`ifndef SYNTH
  a_clear_named: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && (req_i.operation == OP_CLEAR_NAMED)
    |=> (used_q[NamedEff-1:0] == '0))
    else $error("named region not empty after clear");

  a_assign_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && (req_i.operation == OP_ASSIGN) && (rsp.status == ST_OK)
    |-> (SlotW'(rsp.result_number) < SlotW'(NamedEff)))
    else $error("assign granted outside the named region");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && (req_i.operation == OP_ALLOCATE) && (rsp.status == ST_OK)
    |=> ($countones(used_q) == $past($countones(used_q)) + 1))
    else $error("allocate did not mark exactly one number");
`endif

endmodule

@@ rtl/core/srna_output_stage.sv @@
module srna_output_stage
  import srna_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  rsp_t rsp_i,
  output logic space_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  logic valid_q, valid_d;
  rsp_t rsp_q;

  assign space_o = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = rsp_q;

endmodule

@@ rtl/core/split_region_number_allocator_unit.sv @@
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the used map is read and updated
// in the same cycle by flat priority encoders between the two registers.
// Reset: asynchronous, active low; clears the used map and both valid flags, so
// every number is free after reset.
module split_region_number_allocator_unit
  import srna_pkg::*;
#(
  parameter int NAMED_SLOTS = 16,
  parameter int TOTAL_SLOTS = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  logic req_valid;
  req_t req;
  rsp_t rsp;
  logic space;
  logic commit;

  assign commit = req_valid && space;

  srna_input_stage u_input (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (commit),
    .req_valid_o(req_valid),
    .req_o      (req)
  );

  srna_map_core #(
    .NAMED_SLOTS(NAMED_SLOTS),
    .TOTAL_SLOTS(TOTAL_SLOTS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .commit_i(commit),
    .req_i   (req),
    .rsp_o   (rsp)
  );

  srna_output_stage u_output (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (commit),
    .rsp_i      (rsp),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  // input side only stalls when an item sits in both stages
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (req_valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a full pipeline");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import srna_pkg::*;

  localparam int NAMED_SLOTS  = 16;
  localparam int TOTAL_SLOTS  = 128;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_ITEMS  = 190;
  // last phases run with no idling on either side
  localparam int CALM_PHASE   = 8;

  // operation codes with no function; the block ignores them
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_e;

  class number_map_scoreboard;
    bit          used_bits[TOTAL_SLOTS];
    rsp_t        expected_rsp_q[$];
    int unsigned fail_count;

    task report(string what);
      $display("mismatch: %s", what);
      fail_count++;
    endtask

    function void set_letters(ref rsp_t rsp, input int unsigned slot);
      int unsigned offset;
      offset           = slot - NAMED_SLOTS;
      rsp.is_temporary = 1'b1;
      rsp.letter_high  = LETTER_W'(offset / 26);
      rsp.letter_low   = LETTER_W'(offset % 26);
    endfunction

    function rsp_t predict_response(req_t req);
      rsp_t        rsp;
      int unsigned slot;
      bit          found;
      rsp   = '0;
      found = 1'b0;
      case (req.operation)
        OP_ASSIGN: begin
          rsp.status = ST_NO_FREE;
          for (slot = 0; slot < NAMED_SLOTS && slot < TOTAL_SLOTS; slot++) begin
            if (!found && !used_bits[slot]) begin
              found             = 1'b1;
              used_bits[slot]   = 1'b1;
              rsp.result_number = NUM_W'(slot);
              rsp.status        = ST_OK;
            end
          end
        end
        OP_ALLOCATE: begin
          rsp.status = ST_NO_FREE;
          for (slot = NAMED_SLOTS; slot < TOTAL_SLOTS; slot++) begin
            if (!found && !used_bits[slot]) begin
              found             = 1'b1;
              used_bits[slot]   = 1'b1;
              rsp.result_number = NUM_W'(slot);
              rsp.status        = ST_OK;
              set_letters(rsp, slot);
            end
          end
        end
        OP_RELEASE: begin
          if (req.number < TOTAL_SLOTS && used_bits[req.number]) begin
            used_bits[req.number] = 1'b0;
          end else begin
            rsp.status = ST_NOT_USED;
          end
        end
        OP_HIGHEST: begin
          for (slot = TOTAL_SLOTS; slot > NAMED_SLOTS; slot--) begin
            if (!found && used_bits[slot-1]) begin
              found             = 1'b1;
              rsp.result_number = NUM_W'(slot - 1);
            end
          end
        end
        OP_DESCRIBE: begin
          if (req.number < TOTAL_SLOTS && used_bits[req.number]) begin
            rsp.result_number = req.number;
            if (req.number >= NAMED_SLOTS) set_letters(rsp, req.number);
          end else begin
            rsp.status = ST_NOT_USED;
          end
        end
        OP_CLEAR_NAMED: begin
          for (slot = 0; slot < NAMED_SLOTS && slot < TOTAL_SLOTS; slot++) begin
            used_bits[slot] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      return rsp;
    endfunction

    function void note_request(req_t req);
      expected_rsp_q.push_back(predict_response(req));
    endfunction

    task check_response(rsp_t got);
      rsp_t exp;
      if (expected_rsp_q.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp = expected_rsp_q.pop_front();
      if (got.result_number !== exp.result_number)
        report($sformatf("result_number %0d, expected %0d", got.result_number,
                         exp.result_number));
      if (got.status !== exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.is_temporary !== exp.is_temporary)
        report($sformatf("is_temporary %0b, expected %0b", got.is_temporary,
                         exp.is_temporary));
      if (got.letter_high !== exp.letter_high)
        report($sformatf("letter_high %0d, expected %0d", got.letter_high,
                         exp.letter_high));
      if (got.letter_low !== exp.letter_low)
        report($sformatf("letter_low %0d, expected %0d", got.letter_low,
                         exp.letter_low));
    endtask

    // random number currently in use, or any number when the map is empty
    function logic [NUM_W-1:0] pick_used();
      int unsigned hits[$];
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        if (used_bits[i]) hits.push_back(i);
      end
      if (hits.size() == 0) return NUM_W'($urandom_range(0, TOTAL_SLOTS - 1));
      return NUM_W'(hits[$urandom_range(0, hits.size() - 1)]);
    endfunction

    function int unsigned pending();
      return expected_rsp_q.size();
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  req_t in_data_i   = '0;
  logic in_ready_o;
  logic out_valid_o;
  rsp_t out_data_o;

  number_map_scoreboard sb;
  bit          stall_en    = 1'b1;
  int unsigned cycle_count = 0;

  split_region_number_allocator_unit #(
    .NAMED_SLOTS (NAMED_SLOTS),
    .TOTAL_SLOTS (TOTAL_SLOTS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_data_o);
  end

  // receiver back-pressure in bursts
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // valid stays high across back-to-back items; only an idle burst or a drain lowers it
  task automatic send_item(input req_t req);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num);
    req_t req;
    req.operation = op;
    req.number    = num;
    send_item(req);
  endtask

  function automatic req_t make_request(traffic_mode_e mode);
    req_t        req;
    int unsigned roll;
    roll          = $urandom_range(0, 99);
    req.number    = NUM_W'($urandom_range(0, TOTAL_SLOTS - 1));
    req.operation = OP_DESCRIBE;
    case (mode)
      MODE_FILL: begin
        if (roll < 70)      req.operation = OP_ALLOCATE;
        else if (roll < 85) req.operation = OP_ASSIGN;
        else if (roll < 90) req.operation = OP_DESCRIBE;
        else if (roll < 95) req.operation = OP_HIGHEST;
        else                req.operation = OP_RELEASE;
      end
      MODE_DRAIN: begin
        if (roll < 60)      req.operation = OP_RELEASE;
        else if (roll < 75) req.operation = OP_DESCRIBE;
        else if (roll < 85) req.operation = OP_HIGHEST;
        else if (roll < 92) req.operation = OP_ALLOCATE;
        else if (roll < 96) req.operation = OP_ASSIGN;
        else                req.operation = OP_CLEAR_NAMED;
      end
      default: begin
        if (roll < 25)      req.operation = OP_ALLOCATE;
        else if (roll < 40) req.operation = OP_ASSIGN;
        else if (roll < 60) req.operation = OP_RELEASE;
        else if (roll < 78) req.operation = OP_DESCRIBE;
        else if (roll < 90) req.operation = OP_HIGHEST;
        else if (roll < 95) req.operation = OP_CLEAR_NAMED;
        else req.operation = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      end
    endcase
    // mostly aim release and describe at live numbers
    if ((req.operation == OP_RELEASE || req.operation == OP_DESCRIBE) &&
        $urandom_range(0, 3) != 0)
      req.number = sb.pick_used();
    return req;
  endfunction

  initial begin
    traffic_mode_e mode;
    bit            idle_en;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty map, first grants, named vs temporary describe, spare codes
    send_op(OP_HIGHEST, 7'd0);
    send_op(OP_DESCRIBE, 7'd0);
    send_op(OP_RELEASE, 7'd127);
    send_op(OP_ALLOCATE, 7'd0);
    send_op(OP_ASSIGN, 7'd127);
    send_op(OP_DESCRIBE, 7'd16);
    send_op(OP_DESCRIBE, 7'd0);
    send_op(OP_HIGHEST, 7'd127);
    send_op(OP_SPARE_LO, 7'd127);
    send_op(OP_SPARE_HI, 7'd0);
    send_op(OP_DESCRIBE, 7'd15);
    send_op(OP_CLEAR_NAMED, 7'd85);
    send_op(OP_DESCRIBE, 7'd0);
    send_op(OP_RELEASE, 7'd16);
    send_op(OP_RELEASE, 7'd16);
    send_op(OP_HIGHEST, 7'd42);
    send_op(OP_ALLOCATE, 7'd127);
    send_op(OP_DESCRIBE, 7'd127);
    send_op(OP_ASSIGN, 7'd0);
    send_op(OP_RELEASE, 7'd0);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      // two fill phases first so both regions run out
      if (phase < 2)       mode = MODE_FILL;
      else if (phase == 2) mode = MODE_MIXED;
      else if (phase == 3) mode = MODE_DRAIN;
      else                 mode = traffic_mode_e'($urandom_range(0, 2));
      idle_en  = (phase < CALM_PHASE) && ($urandom_range(0, 3) != 0);
      stall_en = (phase < CALM_PHASE) && ($urandom_range(0, 3) != 0);
      if (phase == 4) begin
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (idle_en && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 17));
        send_item(make_request(mode));
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
